### rtl/mcg_pkg.sv
package mcg_pkg;

  localparam int COORD_BITS = 12;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int WIDE_BITS  = COORD_BITS + 2;

  localparam int RADIUS_BYTES = (RAD_BITS + 7) / 8;
  localparam int IN_DATA_BITS = 8 * RADIUS_BYTES;
  localparam int PIXEL_BYTES  = (2 * WIDE_BITS + 7) / 8;
  localparam int OUT_DATA_BITS = 8 * PIXEL_BYTES;

  localparam int CFG_INDEX_BITS = 1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 1'b1;

  localparam int SET_SIZE = 8;
  localparam int SET_IDX_BITS = 3;

  typedef struct packed {
    logic [RAD_BITS-1:0] offset_x;
    logic [RAD_BITS-1:0] offset_y;
    logic                done;
  } set_t;

  typedef struct packed {
    logic empty;
    set_t head;
  } queue_head_t;

endpackage

### rtl/mcg_front.sv
module mcg_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mcg_pkg::IN_DATA_BITS-1:0]   s_tdata,
  input  logic                               s_tuser,
  input  logic                               full,
  output logic                               push,
  output mcg_pkg::set_t                      push_data
);
  import mcg_pkg::*;

  logic [RAD_BITS-1:0]  offset_x, offset_x_next;
  logic [RAD_BITS-1:0]  offset_y, offset_y_next;
  logic [WIDE_BITS-1:0] decision, decision_next;
  logic [WIDE_BITS-1:0] step_east, step_east_next;
  logic [WIDE_BITS-1:0] step_southeast, step_southeast_next;
  logic                 drawing, drawing_next;
  logic                 accept;
  logic [RAD_BITS-1:0]  radius;
  logic                 done;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign radius   = s_tdata[RAD_BITS-1:0];

  always_comb begin
    offset_x_next       = offset_x;
    offset_y_next       = offset_y;
    decision_next       = decision;
    step_east_next      = step_east;
    step_southeast_next = step_southeast;
    drawing_next        = drawing;
    push                = 1'b0;
    if (accept) begin
      if (s_tuser == CMD_START) begin
        offset_x_next       = '0;
        offset_y_next       = radius;
        decision_next       = WIDE_BITS'(1) - {{(WIDE_BITS-RAD_BITS){1'b0}}, radius};
        step_east_next      = WIDE_BITS'(3);
        step_southeast_next = WIDE_BITS'(5)
                            - {{(WIDE_BITS-RAD_BITS-1){1'b0}}, radius, 1'b0};
        push                = 1'b1;
      end else if (drawing) begin
        if (decision[WIDE_BITS-1]) begin
          decision_next       = decision + step_east;
          step_southeast_next = step_southeast + WIDE_BITS'(2);
        end else begin
          decision_next       = decision + step_southeast;
          step_southeast_next = step_southeast + WIDE_BITS'(4);
          offset_y_next       = offset_y - RAD_BITS'(1);
        end
        step_east_next = step_east + WIDE_BITS'(2);
        offset_x_next  = offset_x + RAD_BITS'(1);
        push           = 1'b1;
      end
    end
    done = !(offset_y_next > offset_x_next);
    if (push) begin
      drawing_next = !done;
    end
    push_data.offset_x = offset_x_next;
    push_data.offset_y = offset_y_next;
    push_data.done     = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x       <= '0;
      offset_y       <= '0;
      decision       <= '0;
      step_east      <= '0;
      step_southeast <= '0;
      drawing        <= 1'b0;
    end else begin
      offset_x       <= offset_x_next;
      offset_y       <= offset_y_next;
      decision       <= decision_next;
      step_east      <= step_east_next;
      step_southeast <= step_southeast_next;
      drawing        <= drawing_next;
    end
  end

endmodule

### rtl/mcg_queue.sv
module mcg_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mcg_pkg::set_t        push_data,
  output logic                 full,
  input  logic                 pop,
  output mcg_pkg::queue_head_t head
);
  import mcg_pkg::*;

  set_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head.empty = (count == 2'd0);
  assign head.head  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && !head.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### rtl/mcg_back.sv
module mcg_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [mcg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [mcg_pkg::COORD_BITS-1:0]         cfg_data,
  input  mcg_pkg::queue_head_t                   head,
  output logic                                   pop,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [mcg_pkg::OUT_DATA_BITS-1:0]      m_tdata,
  output logic                                   m_tlast,
  output logic                                   m_tuser
);
  import mcg_pkg::*;

  logic [COORD_BITS-1:0]   center_x;
  logic [COORD_BITS-1:0]   center_y;
  logic [SET_IDX_BITS-1:0] pixel_idx;
  logic                    load;
  logic                    advance;
  logic [RAD_BITS-1:0]     off_a;
  logic [RAD_BITS-1:0]     off_b;
  logic [WIDE_BITS-1:0]    base_x;
  logic [WIDE_BITS-1:0]    base_y;
  logic [WIDE_BITS-1:0]    ext_a;
  logic [WIDE_BITS-1:0]    ext_b;
  logic [WIDE_BITS-1:0]    pixel_x;
  logic [WIDE_BITS-1:0]    pixel_y;
  logic                    is_last;

  assign load    = !m_tvalid || m_tready;
  assign advance = load && !head.empty;
  assign is_last = (pixel_idx == SET_IDX_BITS'(SET_SIZE - 1));
  assign pop     = advance && is_last;

  always_comb begin
    off_a   = pixel_idx[2] ? head.head.offset_y : head.head.offset_x;
    off_b   = pixel_idx[2] ? head.head.offset_x : head.head.offset_y;
    base_x  = {{(WIDE_BITS-COORD_BITS){1'b0}}, center_x};
    base_y  = {{(WIDE_BITS-COORD_BITS){1'b0}}, center_y};
    ext_a   = {{(WIDE_BITS-RAD_BITS){1'b0}}, off_a};
    ext_b   = {{(WIDE_BITS-RAD_BITS){1'b0}}, off_b};
    pixel_x = pixel_idx[1] ? base_x - ext_a : base_x + ext_a;
    pixel_y = pixel_idx[0] ? base_y - ext_b : base_y + ext_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      pixel_idx <= '0;
    end else if (load) begin
      m_tvalid <= !head.empty;
      if (advance) begin
        pixel_idx <= pixel_idx + SET_IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(OUT_DATA_BITS-2*WIDE_BITS){1'b0}}, pixel_y, pixel_x};
      m_tlast <= is_last;
      m_tuser <= is_last && head.head.done;
    end
  end

endmodule

### rtl/midpoint_circle_generator.sv
// Midpoint circle rasteriser with eight-way symmetry about the centre held in
// the center_x and center_y registers. A start request (tuser low) carries a
// radius and emits the eight pixels of (0, radius); each step request (tuser
// high) makes one midpoint decision, advances x and emits eight more pixels.
// A step while no circle is open is dropped. The eighth pixel of every set
// has tlast high, and the eighth pixel of the final set has tuser high.
// Pixels leave one per cycle while the output is ready and a set is queued,
// from a single coordinate adder pair; requests are taken every cycle while
// the two-entry set queue between the decision stage and the pixel stage
// has room. Write the centre registers only while no pixels are pending.
module midpoint_circle_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mcg_pkg::IN_DATA_BITS-1:0]    s_tdata,   // circle_radius
  input  logic                                s_tuser,   // command
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mcg_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // pixel_x, pixel_y
  output logic                                m_tlast,   // last_of_set
  output logic                                m_tuser,   // circle_done
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mcg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mcg_pkg::COORD_BITS-1:0]      cfg_data
);
  import mcg_pkg::*;

  logic        full;
  logic        push;
  set_t        push_data;
  logic        pop;
  queue_head_t head;

  assign cfg_ready = 1'b1;

  mcg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  mcg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head)
  );

  mcg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
